/* sv/pocs_pkg.sv */
package pocs_pkg;

   typedef struct packed {
      logic last;
      logic zero;
      logic neg_re;
      logic neg_im;
   } side_type;

endpackage

/* sv/phase_only_cross_spectrum.sv */
// Phase-only cross spectrum: per transfer, returns conj(a)*b/(|a||b|) as
// signed Q1.(W-1) parts, exactly rounded (ties away from zero), saturated to
// +-(2^(W-1)-1), zero when either sample is zero; tlast passes through. One
// transfer per cycle sustained while rsp_tready holds; the pipeline holds the
// products, the split wide multiplies and one register stage per result bit
// of the normalising root. Stages advance independently, so bubbles close up
// under backpressure.
module phase_only_cross_spectrum #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // a_re, a_im, b_re, b_im
   input  logic [((4*SAMPLE_WIDTH+7)/8)*8-1:0]    req_tdata,
   input  logic                                   req_tlast,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // out_re, out_im
   output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]    rsp_tdata,
   output logic                                   rsp_tlast
);

   localparam int W   = SAMPLE_WIDTH;
   localparam int RW  = 6 * W + 2;
   localparam int N   = W + 5;
   localparam int OUT = N - 1;
   localparam int OW  = ((2*W+7)/8)*8;

   logic [N-1:0] valid_ff, valid_in, en;

   always_comb begin
      en[N-1] = !valid_ff[N-1] || rsp_tready;
      for (int i = N - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
      valid_in[0] = req_tvalid;
      for (int i = 1; i < N; i++) begin
         valid_in[i] = valid_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < N; i++) begin
            if (en[i]) valid_ff[i] <= valid_in[i];
         end
      end
   end

   assign req_tready = en[0];

   // stage 0: products
   logic signed [W-1:0]   a_re, a_im, b_re, b_im;
   logic signed [2*W-1:0] sq_ar_ff, sq_ai_ff, sq_br_ff, sq_bi_ff;
   logic signed [2*W-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   pocs_pkg::side_type    side_ff [4];

   assign a_re = req_tdata[W-1:0];
   assign a_im = req_tdata[2*W-1:W];
   assign b_re = req_tdata[3*W-1:2*W];
   assign b_im = req_tdata[4*W-1:3*W];

   always_ff @(posedge clock) begin
      if (en[0]) begin
         sq_ar_ff <= a_re * a_re;
         sq_ai_ff <= a_im * a_im;
         sq_br_ff <= b_re * b_re;
         sq_bi_ff <= b_im * b_im;
         p_rr_ff  <= a_re * b_re;
         p_ii_ff  <= a_im * b_im;
         p_ri_ff  <= a_re * b_im;
         p_ir_ff  <= b_re * a_im;
         side_ff[0] <= '{last: req_tlast, zero: 1'b0, neg_re: 1'b0, neg_im: 1'b0};
      end
   end

   // stage 1: power and cross terms
   logic [2*W-1:0]      pa_in, pb_in, pa_ff, pb_ff, mre_ff, mim_ff;
   logic signed [2*W:0] re_in, im_in;
   logic [2*W:0]        mre_in, mim_in;

   always_comb begin
      pa_in  = $unsigned(sq_ar_ff) + $unsigned(sq_ai_ff);
      pb_in  = $unsigned(sq_br_ff) + $unsigned(sq_bi_ff);
      re_in  = {p_rr_ff[2*W-1], p_rr_ff} + {p_ii_ff[2*W-1], p_ii_ff};
      im_in  = {p_ri_ff[2*W-1], p_ri_ff} - {p_ir_ff[2*W-1], p_ir_ff};
      mre_in = re_in[2*W] ? $unsigned(-re_in) : $unsigned(re_in);
      mim_in = im_in[2*W] ? $unsigned(-im_in) : $unsigned(im_in);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         pa_ff  <= pa_in;
         pb_ff  <= pb_in;
         mre_ff <= mre_in[2*W-1:0];
         mim_ff <= mim_in[2*W-1:0];
         side_ff[1] <= '{last: side_ff[0].last,
                         zero: (pa_in == '0) || (pb_in == '0),
                         neg_re: re_in[2*W], neg_im: im_in[2*W]};
      end
   end

   // stages 2 and 3: wide products
   logic [4*W-1:0] ab_p, qre_p, qim_p;

   pocs_wmul #(.HW(W)) u_mul_ab (
      .clock(clock), .en_part(en[2]), .en_sum(en[3]), .x(pa_ff), .y(pb_ff), .p(ab_p));
   pocs_wmul #(.HW(W)) u_mul_re (
      .clock(clock), .en_part(en[2]), .en_sum(en[3]), .x(mre_ff), .y(mre_ff), .p(qre_p));
   pocs_wmul #(.HW(W)) u_mul_im (
      .clock(clock), .en_part(en[2]), .en_sum(en[3]), .x(mim_ff), .y(mim_ff), .p(qim_p));

   always_ff @(posedge clock) begin
      if (en[2]) side_ff[2] <= side_ff[1];
      if (en[3]) side_ff[3] <= side_ff[2];
   end

   // stage 4: root set-up, x = -1
   pocs_pkg::side_type   init_side_ff;
   logic [4*W-1:0]       init_ab_ff;
   logic signed [RW-1:0] init_r_re_ff, init_r_im_ff, init_t_ff;
   logic signed [RW-1:0] ab_ext;

   assign ab_ext = $signed({{(RW-4*W){1'b0}}, ab_p});

   always_ff @(posedge clock) begin
      if (en[4]) begin
         init_side_ff <= side_ff[3];
         init_ab_ff   <= ab_p;
         init_r_re_ff <= $signed({2'b00, qre_p, {(2*W){1'b0}}}) - ab_ext;
         init_r_im_ff <= $signed({2'b00, qim_p, {(2*W){1'b0}}}) - ab_ext;
         init_t_ff    <= -ab_ext;
      end
   end

   // digit stages
   pocs_pkg::side_type   d_side [W];
   logic [4*W-1:0]       d_ab   [W];
   logic signed [RW-1:0] d_r_re [W];
   logic signed [RW-1:0] d_t_re [W];
   logic signed [RW-1:0] d_r_im [W];
   logic signed [RW-1:0] d_t_im [W];
   logic [W-2:0]         d_k_re [W];
   logic [W-2:0]         d_k_im [W];

   assign d_side[0] = init_side_ff;
   assign d_ab[0]   = init_ab_ff;
   assign d_r_re[0] = init_r_re_ff;
   assign d_t_re[0] = init_t_ff;
   assign d_r_im[0] = init_r_im_ff;
   assign d_t_im[0] = init_t_ff;
   assign d_k_re[0] = '0;
   assign d_k_im[0] = '0;

   for (genvar g = 1; g < W; g++) begin : g_digit
      pocs_digit #(.W(W), .J(W - 1 - g)) u_digit (
         .clock(clock), .en(en[4+g]),
         .side_in(d_side[g-1]), .ab_in(d_ab[g-1]),
         .r_re_in(d_r_re[g-1]), .t_re_in(d_t_re[g-1]), .k_re_in(d_k_re[g-1]),
         .r_im_in(d_r_im[g-1]), .t_im_in(d_t_im[g-1]), .k_im_in(d_k_im[g-1]),
         .side_out(d_side[g]), .ab_out(d_ab[g]),
         .r_re_out(d_r_re[g]), .t_re_out(d_t_re[g]), .k_re_out(d_k_re[g]),
         .r_im_out(d_r_im[g]), .t_im_out(d_t_im[g]), .k_im_out(d_k_im[g]));
   end

   // output stage
   logic [W-1:0] out_re_in, out_im_in, out_re_ff, out_im_ff, k_re_ext, k_im_ext;
   logic         out_last_ff, out_zero_ff;

   always_comb begin
      k_re_ext  = {1'b0, d_k_re[W-1]};
      k_im_ext  = {1'b0, d_k_im[W-1]};
      out_re_in = d_side[W-1].neg_re ? -k_re_ext : k_re_ext;
      out_im_in = d_side[W-1].neg_im ? -k_im_ext : k_im_ext;
      if (d_side[W-1].zero) begin
         out_re_in = '0;
         out_im_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[OUT]) begin
         out_re_ff   <= out_re_in;
         out_im_ff   <= out_im_in;
         out_last_ff <= d_side[W-1].last;
         out_zero_ff <= d_side[W-1].zero;
      end
   end

   assign rsp_tvalid = valid_ff[OUT];
   assign rsp_tdata  = {{(OW-2*W){1'b0}}, out_im_ff, out_re_ff};
   assign rsp_tlast  = out_last_ff;

`ifndef ASSERT_OFF
   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_zero_ff |-> out_re_ff == '0 && out_im_ff == '0)
      else $error("zero magnitude gave a non-zero result");
   a_no_min_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> out_re_ff != {1'b1, {(W-1){1'b0}}}
                  && out_im_ff != {1'b1, {(W-1){1'b0}}})
      else $error("most negative code produced");
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[OUT] |-> req_tready)
      else $error("input stalled with output stage empty");
   a_advance: assert property (@(posedge clock) disable iff (reset)
      valid_ff[OUT-1] && en[OUT] |=> rsp_tvalid)
      else $error("transfer lost at output stage");
`endif

endmodule

/* sv/pocs_wmul.sv */
// unsigned 2H x 2H product from four H x H partials, two register stages
module pocs_wmul #(
   parameter int HW = 16
) (
   input  logic              clock,
   input  logic              en_part,
   input  logic              en_sum,
   input  logic [2*HW-1:0]   x,
   input  logic [2*HW-1:0]   y,
   output logic [4*HW-1:0]   p
);

   logic [2*HW-1:0] hh_ff, hl_ff, lh_ff, ll_ff;
   logic [4*HW-1:0] p_ff, p_in;

   always_ff @(posedge clock) begin
      if (en_part) begin
         hh_ff <= x[2*HW-1:HW] * y[2*HW-1:HW];
         hl_ff <= x[2*HW-1:HW] * y[HW-1:0];
         lh_ff <= x[HW-1:0] * y[2*HW-1:HW];
         ll_ff <= x[HW-1:0] * y[HW-1:0];
      end
   end

   always_comb begin
      p_in = {hh_ff, ll_ff}
           + {{HW{1'b0}}, hl_ff, {HW{1'b0}}}
           + {{HW{1'b0}}, lh_ff, {HW{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (en_sum) begin
         p_ff <= p_in;
      end
   end

   assign p = p_ff;

endmodule

/* sv/pocs_digit.sv */
// one quotient bit of the normalising root, both lanes
// residual r = L - x^2*ab, t = x*ab, with x = 2k-1
module pocs_digit #(
   parameter int W = 16,
   parameter int J = 0
) (
   input  logic                       clock,
   input  logic                       en,
   input  pocs_pkg::side_type         side_in,
   input  logic [4*W-1:0]             ab_in,
   input  logic signed [6*W+1:0]      r_re_in,
   input  logic signed [6*W+1:0]      t_re_in,
   input  logic [W-2:0]               k_re_in,
   input  logic signed [6*W+1:0]      r_im_in,
   input  logic signed [6*W+1:0]      t_im_in,
   input  logic [W-2:0]               k_im_in,
   output pocs_pkg::side_type         side_out,
   output logic [4*W-1:0]             ab_out,
   output logic signed [6*W+1:0]      r_re_out,
   output logic signed [6*W+1:0]      t_re_out,
   output logic [W-2:0]               k_re_out,
   output logic signed [6*W+1:0]      r_im_out,
   output logic signed [6*W+1:0]      t_im_out,
   output logic [W-2:0]               k_im_out
);

   localparam int RW = 6 * W + 2;

   logic signed [RW-1:0] ab_ext, ab_sq, ab_lin;
   logic signed [RW-1:0] rc_re, rc_im;
   logic signed [RW-1:0] r_re_in_v, t_re_in_v, r_im_in_v, t_im_in_v;
   logic [W-2:0]         k_re_in_v, k_im_in_v;

   pocs_pkg::side_type   side_ff;
   logic [4*W-1:0]       ab_ff;
   logic signed [RW-1:0] r_re_ff, t_re_ff, r_im_ff, t_im_ff;
   logic [W-2:0]         k_re_ff, k_im_ff;

   always_comb begin
      ab_ext = $signed({{(RW-4*W){1'b0}}, ab_in});
      ab_sq  = ab_ext <<< (2 * J + 2);
      ab_lin = ab_ext <<< (J + 1);
      rc_re  = r_re_in - (t_re_in <<< (J + 2)) - ab_sq;
      rc_im  = r_im_in - (t_im_in <<< (J + 2)) - ab_sq;
      r_re_in_v = r_re_in;
      t_re_in_v = t_re_in;
      k_re_in_v = k_re_in;
      r_im_in_v = r_im_in;
      t_im_in_v = t_im_in;
      k_im_in_v = k_im_in;
      if (!rc_re[RW-1]) begin
         r_re_in_v = rc_re;
         t_re_in_v = t_re_in + ab_lin;
         k_re_in_v[J] = 1'b1;
      end
      if (!rc_im[RW-1]) begin
         r_im_in_v = rc_im;
         t_im_in_v = t_im_in + ab_lin;
         k_im_in_v[J] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= side_in;
         ab_ff   <= ab_in;
         r_re_ff <= r_re_in_v;
         t_re_ff <= t_re_in_v;
         k_re_ff <= k_re_in_v;
         r_im_ff <= r_im_in_v;
         t_im_ff <= t_im_in_v;
         k_im_ff <= k_im_in_v;
      end
   end

   assign side_out = side_ff;
   assign ab_out   = ab_ff;
   assign r_re_out = r_re_ff;
   assign t_re_out = t_re_ff;
   assign k_re_out = k_re_ff;
   assign r_im_out = r_im_ff;
   assign t_im_out = t_im_ff;
   assign k_im_out = k_im_ff;

endmodule

/* tb/phase_only_cross_spectrum_tb.sv */
module phase_only_cross_spectrum_tb;

   localparam int W = 16;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = W + 20;
   localparam int N_RANDOM = 430;

   typedef struct {
      logic signed [W-1:0] re;
      logic signed [W-1:0] im;
      logic                last;
   } phasor_type;

   typedef struct {
      logic signed [W-1:0] a_re, a_im, b_re, b_im;
      logic                last;
      bit                  typed;
      logic signed [W-1:0] exp_re, exp_im;
   } vector_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [63:0]   req_tdata = '0;   // a_re, a_im, b_re, b_im
   logic          req_tlast = 1'b0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [31:0]   rsp_tdata;        // out_re, out_im
   logic          rsp_tlast;

   phasor_type phasor_q[$];
   int      errors = 0;
   int      idle_cycles = 0;
   bit      rx_quiet = 1'b0;
   bit      rx_hold_req = 1'b0;
   bit      rx_hold_ack = 1'b0;
   int      rx_gap = 0;

   phase_only_cross_spectrum #(.SAMPLE_WIDTH(W)) u_dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // largest k with (2k-1)^2 * ab <= (2^W * p)^2, capped at full scale - 1
   function automatic logic [W-1:0] unit_part(longint unsigned p, bit [127:0] ab);
      bit [127:0] t, lhs, rhs;
      longint unsigned lo, hi, mid, odd;
      t = 128'(p) << W;
      lhs = t * t;
      lo = 0;
      hi = (64'd1 << (W-1)) - 1;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         odd = 2 * mid - 1;
         rhs = 128'(odd * odd) * ab;
         if (lhs >= rhs) lo = mid;
         else hi = mid - 1;
      end
      return lo[W-1:0];
   endfunction

   function automatic phasor_type predict_phasor(logic signed [W-1:0] ar, ai, br, bi,
                                                 logic last);
      phasor_type r;
      longint pa, pb, sre, sim;
      logic [W-1:0] kre, kim;
      pa = longint'(ar) * ar + longint'(ai) * ai;
      pb = longint'(br) * br + longint'(bi) * bi;
      r.last = last;
      r.re = '0;
      r.im = '0;
      if (pa != 0 && pb != 0) begin
         sre = longint'(ar) * br + longint'(ai) * bi;
         sim = longint'(ar) * bi - longint'(br) * ai;
         kre = unit_part(sre < 0 ? -sre : sre, 128'(pa) * 128'(pb));
         kim = unit_part(sim < 0 ? -sim : sim, 128'(pa) * 128'(pb));
         r.re = sre < 0 ? -kre : kre;
         r.im = sim < 0 ? -kim : kim;
      end
      return r;
   endfunction

   // acceptance on both channels; expectations join on the input side
   always @(posedge clock) begin
      phasor_type e;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (req_tvalid && req_tready)
            phasor_q.push_back(predict_phasor(req_tdata[15:0], req_tdata[31:16],
                                              req_tdata[47:32], req_tdata[63:48], req_tlast));
         if (rsp_tvalid && rsp_tready) begin
            if (phasor_q.size() == 0) begin
               $error("unexpected transfer: re %0d im %0d", $signed(rsp_tdata[15:0]),
                      $signed(rsp_tdata[31:16]));
               errors++;
            end else begin
               e = phasor_q.pop_front();
               if (rsp_tdata[15:0] !== e.re) begin
                  $error("out_re: expected %0d, got %0d", e.re, $signed(rsp_tdata[15:0]));
                  errors++;
               end
               if (rsp_tdata[31:16] !== e.im) begin
                  $error("out_im: expected %0d, got %0d", e.im, $signed(rsp_tdata[31:16]));
                  errors++;
               end
               if (rsp_tlast !== e.last) begin
                  $error("last_out: expected %0b, got %0b", e.last, rsp_tlast);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[phase_only_cross_spectrum] ERROR");
         $finish;
      end
   end

   // receiver: short random stalls, occasional long ones, one forced hold-off
   always @(posedge clock) begin
      int r;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rx_gap > 0) begin
         rx_gap <= rx_gap - 1;
         rsp_tready <= 1'b0;
      end else if (rx_hold_req != rx_hold_ack) begin
         rx_hold_ack <= rx_hold_req;
         rx_gap <= 200;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         r = $urandom_range(0, 99);
         if (!rx_quiet && r < 15)
            rx_gap <= (r < 2) ? $urandom_range(20, 60) : $urandom_range(1, 3);
      end
   end

   task automatic send(logic signed [W-1:0] ar, ai, br, bi, logic last, int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {bi, br, ai, ar};
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic int tx_gap(bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 70) return 0;
      if (r < 96) return $urandom_range(1, 3);
      return $urandom_range(15, 50);
   endfunction

   function automatic logic signed [W-1:0] pick_sample();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 16'($urandom);
      if (r < 75) return $signed(16'($urandom_range(0, 7))) - 16'sd4;
      if (r < 85) return 16'sd0;
      case ($urandom_range(0, 3))
         0: return -16'sd32768;
         1: return 16'sd32767;
         2: return -16'sd32767;
         default: return 16'sd1;
      endcase
   endfunction

   vector_type directed[] = '{
      '{0, 0, 0, 0, 0, 1, 0, 0},
      '{16'sd1000, 16'sd2000, 0, 0, 1, 1, 0, 0},
      '{0, 0, -16'sd32768, 16'sd5, 0, 1, 0, 0},
      '{16'sd12345, -16'sd321, 16'sd12345, -16'sd321, 0, 1, 16'sd32767, 0},
      '{16'sd300, 16'sd400, -16'sd300, -16'sd400, 1, 1, -16'sd32767, 0},
      '{16'sd1, 0, 0, 16'sd1, 0, 1, 0, 16'sd32767},
      '{16'sd1, 0, 0, -16'sd1, 0, 1, 0, -16'sd32767},
      '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 0, 1, 16'sd32767, 0},
      '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1, 1, 16'sd32767, 0},
      '{-16'sd32768, 0, 16'sd32767, 0, 0, 1, -16'sd32767, 0},
      '{-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 0, 0, 0, 0},
      '{16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 0, 0, 0, 0},
      '{16'sd1, 16'sd1, 16'sd1, -16'sd1, 0, 0, 0, 0},
      '{16'sd1, 16'sd2, 16'sd3, 16'sd4, 1, 0, 0, 0},
      '{-16'sd1, -16'sd1, 16'sd32767, 16'sd1, 0, 0, 0, 0},
      '{16'sd3, 16'sd4, 16'sd4, 16'sd3, 0, 0, 0, 0},
      '{16'sd1, 0, 16'sd1, 16'sd1, 0, 0, 0, 0},
      '{-16'sd21846, 16'sd12000, -16'sd7, 16'sd30001, 1, 0, 0, 0},
      '{16'sh5555, -16'sh5556, -16'sh2aab, 16'sh2aaa, 0, 0, 0, 0}
   };

   initial begin
      phasor_type p;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // typed rows are checked against their literals as well
      foreach (directed[i]) begin
         if (directed[i].typed) begin
            p = predict_phasor(directed[i].a_re, directed[i].a_im, directed[i].b_re,
                               directed[i].b_im, directed[i].last);
            if (p.re !== directed[i].exp_re || p.im !== directed[i].exp_im) begin
               $error("row %0d: expected %0d %0d, predictor %0d %0d", i,
                      directed[i].exp_re, directed[i].exp_im, p.re, p.im);
               errors++;
            end
         end
         send(directed[i].a_re, directed[i].a_im, directed[i].b_re, directed[i].b_im,
              directed[i].last, tx_gap(1'b0));
      end

      // long receiver hold-off while the sender streams back to back
      rx_hold_req <= !rx_hold_req;
      for (int i = 0; i < 60; i++)
         send(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
              $urandom_range(0, 7) == 0, 0);

      req_tvalid <= 1'b0;
      while (phasor_q.size() != 0) @(posedge clock);
      @(posedge clock);

      for (int i = 0; i < N_RANDOM - 60; i++) begin
         if (i == 150) rx_quiet <= 1'b1;
         if (i == 230) rx_quiet <= 1'b0;
         send(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
              $urandom_range(0, 7) == 0, tx_gap(i >= 150 && i < 230));
      end
      req_tvalid <= 1'b0;

      while (phasor_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && phasor_q.size() == 0) begin
         $display("[phase_only_cross_spectrum] OK");
      end else begin
         $display("[phase_only_cross_spectrum] ERROR");
      end
      $finish;
   end

endmodule
